@@ rtl/srtf_pkg.sv @@
// ----------------------------------------------------------------------------
// srtf_pkg
// Shared constants, field layout and controller/datapath handshake types for
// the shortest-remaining-time-first tick scheduler.
// ----------------------------------------------------------------------------
package srtf_pkg;

   localparam int SLOTS_DEF     = 8;
   localparam int TIME_BITS_DEF = 16;

   localparam int SLOT_FLD_W = 3;
   localparam int ARR_W      = 16;
   localparam int BUR_W      = 16;
   localparam int LEFT_W     = 16;
   localparam int TICK_W     = 16;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   localparam int REQ_SLOT_LSB = 0;
   localparam int REQ_ARR_LSB  = REQ_SLOT_LSB + SLOT_FLD_W;
   localparam int REQ_BUR_LSB  = REQ_ARR_LSB + ARR_W;

   localparam int RSP_BITS = TICK_W + 1 + SLOT_FLD_W + 3 + LEFT_W;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   typedef struct packed {
      logic load_wr;
      logic tick_start;
      logic scan_go;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic out_free;
   } dp_stat_type;

endpackage

@@ rtl/srtf_ctrl.sv @@
// ----------------------------------------------------------------------------
// srtf_ctrl
// Sequencer: accepts a transaction, issues a load write or runs the slot scan and commits the pick.
// ----------------------------------------------------------------------------
module srtf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_tuser,
   input  srtf_pkg::dp_stat_type stat,
   output srtf_pkg::ctrl_cmd_type cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_COMMIT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in        = state_ff;
      cmd.load_wr     = 1'b0;
      cmd.tick_start  = 1'b0;
      cmd.scan_go     = 1'b0;
      cmd.commit      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_tuser == srtf_pkg::REQ_TICK) begin
                  cmd.tick_start = 1'b1;
                  state_in       = S_SCAN;
               end else begin
                  cmd.load_wr = 1'b1;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_go = 1'b1;
            if (stat.scan_done) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/srtf_dpath.sv @@
// ----------------------------------------------------------------------------
// srtf_dpath
// Slot memory, per-slot flags, scan pipeline with running minimum, time
// counter and result register.
// ----------------------------------------------------------------------------
module srtf_dpath #(
   parameter int SLOTS     = srtf_pkg::SLOTS_DEF,
   parameter int TIME_BITS = srtf_pkg::TIME_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  srtf_pkg::ctrl_cmd_type             cmd,
   output srtf_pkg::dp_stat_type              stat,
   input  logic [srtf_pkg::SLOT_FLD_W-1:0]    ld_slot,
   input  logic [srtf_pkg::ARR_W-1:0]         ld_arrival,
   input  logic [srtf_pkg::BUR_W-1:0]         ld_burst,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [srtf_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CMP_W  = (TIME_BITS > srtf_pkg::ARR_W) ? TIME_BITS : srtf_pkg::ARR_W;
   localparam int MEM_W  = srtf_pkg::ARR_W + srtf_pkg::BUR_W + srtf_pkg::LEFT_W;
   localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

   // entry layout: {arrival, burst, left}
   logic [MEM_W-1:0]           job_mem [SLOTS];
   logic [MEM_W-1:0]           rd_data_ff;
   logic                       wr_en;
   logic [SLOT_W-1:0]          wr_addr;
   logic [MEM_W-1:0]           wr_data;

   logic [SLOTS-1:0]           loaded_ff;
   logic [SLOTS-1:0]           ready_ff;
   logic [SLOTS-1:0]           started_ff;

   logic [SLOT_W-1:0]          cnt_ff;
   logic                       issue_ff;
   logic                       ev_valid_ff;
   logic [SLOT_W-1:0]          ev_idx_ff;

   logic                       best_valid_ff;
   logic [SLOT_W-1:0]          best_idx_ff;
   logic [srtf_pkg::LEFT_W-1:0] best_left_ff;
   logic [srtf_pkg::ARR_W-1:0] best_arr_ff;
   logic [srtf_pkg::BUR_W-1:0] best_bur_ff;
   logic                       best_first_ff;

   logic [TIME_BITS-1:0]       now_ff;
   logic                       last_valid_ff;
   logic [SLOT_W-1:0]          last_idx_ff;

   logic                       rsp_valid_ff;
   logic [srtf_pkg::RSP_BITS-1:0] rsp_bits_ff;
   logic [srtf_pkg::RSP_BITS-1:0] rsp_bits_in;

   logic [srtf_pkg::ARR_W-1:0] ev_arr;
   logic [srtf_pkg::BUR_W-1:0] ev_bur;
   logic [srtf_pkg::LEFT_W-1:0] ev_left;
   logic                       ev_arrive;
   logic [srtf_pkg::LEFT_W-1:0] cand_left;
   logic                       cand_ok;
   logic                       cand_win;
   logic                       ld_in_range;
   logic [SLOT_W-1:0]          ld_idx;
   logic [srtf_pkg::LEFT_W-1:0] new_left;
   logic                       switched;

   assign ev_arr  = rd_data_ff[MEM_W-1 -: srtf_pkg::ARR_W];
   assign ev_bur  = rd_data_ff[srtf_pkg::LEFT_W +: srtf_pkg::BUR_W];
   assign ev_left = rd_data_ff[srtf_pkg::LEFT_W-1:0];

   assign ev_arrive = ev_valid_ff && loaded_ff[ev_idx_ff] && !ready_ff[ev_idx_ff]
                      && (CMP_W'(ev_arr) <= CMP_W'(now_ff));
   assign cand_left = ev_arrive ? ev_bur : ev_left;
   assign cand_ok   = ev_valid_ff && (ready_ff[ev_idx_ff] || ev_arrive)
                      && (cand_left != '0);
   assign cand_win  = cand_ok && (!best_valid_ff || (cand_left < best_left_ff));

   assign ld_in_range = (int'(ld_slot) < SLOTS);
   assign ld_idx      = SLOT_W'(ld_slot);
   assign new_left    = best_left_ff - srtf_pkg::LEFT_W'(1);
   assign switched    = !last_valid_ff || (best_idx_ff != last_idx_ff);

   assign stat.scan_done = ev_valid_ff && (ev_idx_ff == LAST_IDX) && !issue_ff;
   assign stat.out_free  = !rsp_valid_ff || rsp_tready;

   // single write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ev_idx_ff;
      wr_data = {ev_arr, ev_bur, ev_bur};
      if (cmd.load_wr) begin
         wr_en   = ld_in_range;
         wr_addr = ld_idx;
         wr_data = {ld_arrival, ld_burst, srtf_pkg::LEFT_W'(0)};
      end else if (cmd.commit) begin
         wr_en   = best_valid_ff;
         wr_addr = best_idx_ff;
         wr_data = {best_arr_ff, best_bur_ff, new_left};
      end else if (cmd.scan_go) begin
         wr_en = ev_arrive;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         job_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= job_mem[cnt_ff];
   end

   always_comb begin
      if (best_valid_ff) begin
         rsp_bits_in = {new_left, switched, (new_left == '0), best_first_ff,
                        srtf_pkg::SLOT_FLD_W'(best_idx_ff), 1'b1,
                        srtf_pkg::TICK_W'(now_ff)};
      end else begin
         rsp_bits_in = {{(srtf_pkg::RSP_BITS - srtf_pkg::TICK_W){1'b0}},
                        srtf_pkg::TICK_W'(now_ff)};
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff     <= '0;
         ready_ff      <= '0;
         started_ff    <= '0;
         cnt_ff        <= '0;
         issue_ff      <= 1'b0;
         ev_valid_ff   <= 1'b0;
         best_valid_ff <= 1'b0;
         now_ff        <= '0;
         last_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.load_wr && ld_in_range) begin
            loaded_ff[ld_idx]  <= 1'b1;
            ready_ff[ld_idx]   <= 1'b0;
            started_ff[ld_idx] <= 1'b0;
         end
         if (cmd.tick_start) begin
            cnt_ff        <= '0;
            issue_ff      <= 1'b1;
            ev_valid_ff   <= 1'b0;
            best_valid_ff <= 1'b0;
         end
         if (cmd.scan_go) begin
            ev_valid_ff <= issue_ff;
            if (issue_ff) begin
               if (cnt_ff == LAST_IDX) begin
                  issue_ff <= 1'b0;
               end else begin
                  cnt_ff <= cnt_ff + SLOT_W'(1);
               end
            end
            if (ev_arrive) begin
               ready_ff[ev_idx_ff] <= 1'b1;
            end
            if (cand_win) begin
               best_valid_ff <= 1'b1;
            end
         end
         if (cmd.commit) begin
            ev_valid_ff  <= 1'b0;
            rsp_valid_ff <= 1'b1;
            if (now_ff != '1) begin
               now_ff <= now_ff + TIME_BITS'(1);
            end
            if (best_valid_ff) begin
               started_ff[best_idx_ff] <= 1'b1;
               last_valid_ff           <= 1'b1;
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.scan_go) begin
         ev_idx_ff <= cnt_ff;
         if (cand_win) begin
            best_idx_ff   <= ev_idx_ff;
            best_left_ff  <= cand_left;
            best_arr_ff   <= ev_arr;
            best_bur_ff   <= ev_bur;
            best_first_ff <= !started_ff[ev_idx_ff];
         end
      end
      if (cmd.commit) begin
         rsp_bits_ff <= rsp_bits_in;
         if (best_valid_ff) begin
            last_idx_ff <= best_idx_ff;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = srtf_pkg::RSP_DATA_W'(rsp_bits_ff);

endmodule

@@ rtl/srtf_tick_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// srtf_tick_scheduler_top
// Preemptive shortest-remaining-time-first scheduler over a table of job slots.
// ----------------------------------------------------------------------------
// A load transaction (tuser 0) writes a slot's arrival and burst and returns
// nothing; a slot index of SLOTS or more is dropped. A tick transaction
// (tuser 1) scans every slot through the registered read port of the slot
// memory, one slot per cycle, promoting arrived jobs and tracking the least
// nonzero remaining time, then commits the pick into the result register and
// advances the saturating time counter. The next transaction is accepted in
// the cycle after the commit, so a tick is not overlapped with the next
// transaction; one result per tick, idle ticks included. The next transaction
// is taken while a result still waits on rsp_tready.
module srtf_tick_scheduler_top #(
   parameter int SLOTS     = srtf_pkg::SLOTS_DEF,
   parameter int TIME_BITS = srtf_pkg::TIME_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // slot[2:0], arrival_time[18:3], burst_time[34:19], zero pad
   input  logic [srtf_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type[0]
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // tick_time[15:0], busy_res[16], running_slot[19:17], first_run[20],
   // finished[21], switched[22], remaining_after[38:23], zero pad
   output logic [srtf_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   srtf_pkg::ctrl_cmd_type cmd;
   srtf_pkg::dp_stat_type  stat;

   srtf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   srtf_dpath #(
      .SLOTS     (SLOTS),
      .TIME_BITS (TIME_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .ld_slot    (req_tdata[srtf_pkg::REQ_SLOT_LSB +: srtf_pkg::SLOT_FLD_W]),
      .ld_arrival (req_tdata[srtf_pkg::REQ_ARR_LSB +: srtf_pkg::ARR_W]),
      .ld_burst   (req_tdata[srtf_pkg::REQ_BUR_LSB +: srtf_pkg::BUR_W]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the shortest-remaining-time-first tick scheduler.
// A predictor of the slot table follows every accepted load and tick
// transaction, and each tick report from the block is compared field by field
// with the oldest prediction. Directed cases cover idle ticks, preemption,
// ties, zero bursts, reloads and field extremes. A random mix of loads and
// ticks follows.
// ----------------------------------------------------------------------------
module testbench;

   localparam int                          NSLOT     = srtf_pkg::SLOTS_DEF;
   localparam logic [3:0]                  NO_SLOT   = 4'd15;
   localparam logic [srtf_pkg::TICK_W-1:0] TIME_CEIL = '1;

   // packed from rsp_tdata bit 0 upward: tick_time first, remaining last
   typedef struct packed {
      logic [srtf_pkg::LEFT_W-1:0]     remaining;
      logic                            switched;
      logic                            finished;
      logic                            first_run;
      logic [srtf_pkg::SLOT_FLD_W-1:0] slot;
      logic                            busy;
      logic [srtf_pkg::TICK_W-1:0]     tick_time;
   } tick_report_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [srtf_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                            req_tuser;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [srtf_pkg::RSP_DATA_W-1:0] rsp_tdata;

   logic [srtf_pkg::ARR_W-1:0]  slot_arrival [NSLOT];
   logic [srtf_pkg::BUR_W-1:0]  slot_burst   [NSLOT];
   logic [srtf_pkg::LEFT_W-1:0] slot_left    [NSLOT];
   logic                        slot_loaded  [NSLOT];
   logic                        slot_ready   [NSLOT];
   logic                        slot_started [NSLOT];
   logic [srtf_pkg::TICK_W-1:0] sched_now;
   logic [3:0]                  sched_last;

   tick_report_type tick_reports_q[$];

   logic calm;
   int   mismatches   = 0;
   int   loads_sent   = 0;
   int   ticks_sent   = 0;
   int   busy_seen    = 0;
   int   idle_seen    = 0;
   int   done_seen    = 0;

   srtf_tick_scheduler_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready = calm || ($urandom_range(99) >= 35);
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic int idle_gap();
      int n;
      n = 0;
      if (calm) return 0;
      while ($urandom_range(99) < 35) n++;
      if ($urandom_range(99) < 4) n += $urandom_range(5, 20);
      return n;
   endfunction

   function automatic logic [15:0] clip16(input int unsigned v);
      return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
   endfunction

   task automatic apply_load(input logic [2:0] s, input logic [15:0] a, input logic [15:0] b);
      slot_arrival[s] = a;
      slot_burst[s]   = b;
      slot_left[s]    = '0;
      slot_loaded[s]  = 1'b1;
      slot_ready[s]   = 1'b0;
      slot_started[s] = 1'b0;
   endtask

   task automatic predict_tick();
      tick_report_type r;
      int              pick;
      logic [15:0]     least;
      pick  = -1;
      least = '0;
      for (int k = 0; k < NSLOT; k++) begin
         if (slot_loaded[k] && !slot_ready[k] && slot_arrival[k] <= sched_now) begin
            slot_ready[k] = 1'b1;
            slot_left[k]  = slot_burst[k];
         end
      end
      for (int k = 0; k < NSLOT; k++) begin
         if (slot_ready[k] && slot_left[k] != 0 && (pick < 0 || slot_left[k] < least)) begin
            pick  = k;
            least = slot_left[k];
         end
      end
      r = '0;
      r.tick_time = sched_now;
      if (pick >= 0) begin
         r.busy            = 1'b1;
         r.slot            = pick[2:0];
         r.first_run       = !slot_started[pick];
         slot_started[pick] = 1'b1;
         slot_left[pick]   = slot_left[pick] - 1'b1;
         r.finished        = (slot_left[pick] == 0);
         r.switched        = ({1'b0, pick[2:0]} != sched_last);
         r.remaining       = slot_left[pick];
         sched_last        = {1'b0, pick[2:0]};
      end
      if (sched_now != TIME_CEIL) sched_now = sched_now + 1'b1;
      tick_reports_q.push_back(r);
   endtask

   task automatic send_item(input logic kind, input logic [2:0] s, input logic [15:0] a,
                            input logic [15:0] b);
      int gap;
      gap = idle_gap();
      @(negedge clock);
      repeat (gap) begin
         req_tvalid = 1'b0;
         req_tuser  = 1'($urandom_range(1));
         req_tdata  = srtf_pkg::REQ_DATA_W'({$urandom, $urandom});
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = '0;
      req_tdata[srtf_pkg::REQ_SLOT_LSB +: srtf_pkg::SLOT_FLD_W] = s;
      req_tdata[srtf_pkg::REQ_ARR_LSB +: srtf_pkg::ARR_W]       = a;
      req_tdata[srtf_pkg::REQ_BUR_LSB +: srtf_pkg::BUR_W]       = b;
      do @(posedge clock); while (!req_tready);
      if (kind == srtf_pkg::REQ_LOAD) begin
         loads_sent++;
         apply_load(s, a, b);
      end else begin
         ticks_sent++;
         predict_tick();
      end
   endtask

   task automatic send_load(input logic [2:0] s, input logic [15:0] a, input logic [15:0] b);
      send_item(srtf_pkg::REQ_LOAD, s, a, b);
   endtask

   task automatic send_tick();
      send_item(srtf_pkg::REQ_TICK, 3'($urandom_range(7)), 16'($urandom), 16'($urandom));
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      tick_report_type got;
      tick_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[srtf_pkg::RSP_BITS-1:0];
         if (tick_reports_q.size() == 0) begin
            $error("tick report with none pending: tick_time %0d", got.tick_time);
            mismatches++;
         end else begin
            want = tick_reports_q.pop_front();
            check_field("tick_time", 32'(want.tick_time), 32'(got.tick_time));
            check_field("busy_res", 32'(want.busy), 32'(got.busy));
            check_field("running_slot", 32'(want.slot), 32'(got.slot));
            check_field("first_run", 32'(want.first_run), 32'(got.first_run));
            check_field("finished", 32'(want.finished), 32'(got.finished));
            check_field("switched", 32'(want.switched), 32'(got.switched));
            check_field("remaining_after", 32'(want.remaining), 32'(got.remaining));
            if (want.busy) busy_seen++;
            else idle_seen++;
            if (want.finished) done_seen++;
         end
      end
   end

   task automatic test_idle_ticks();
      repeat (2) send_tick();
   endtask

   task automatic test_preemption();
      send_load(3'd3, 16'd0, 16'd5);
      send_load(3'd5, 16'd3, 16'd1);
      repeat (3) send_tick();
   endtask

   task automatic test_ties();
      send_load(3'd6, 16'd0, 16'd3);
      send_load(3'd1, 16'd0, 16'd3);
      repeat (2) send_tick();
   endtask

   task automatic test_zero_burst();
      send_load(3'd0, 16'd0, 16'd0);
      send_tick();
   endtask

   task automatic test_reload_extremes();
      send_load(3'd1, 16'hFFFF, 16'hFFFF);
      send_tick();
      send_load(3'd7, 16'd0, 16'd1);
      send_tick();
      send_load(3'd2, 16'd0, 16'hFFFF);
      send_tick();
   endtask

   task automatic test_random_mix(input int count);
      logic [15:0] a;
      logic [15:0] b;
      int          r;
      for (int i = 0; i < count; i++) begin
         calm = (i >= count / 3) && (i < count / 3 + 200);
         if ($urandom_range(99) < 30) begin
            r = $urandom_range(99);
            if (r < 60)      a = clip16(sched_now + $urandom_range(24));
            else if (r < 80) a = 16'($urandom_range(sched_now));
            else             a = 16'($urandom);
            r = $urandom_range(99);
            if (r < 10)      b = '0;
            else if (r < 85) b = 16'($urandom_range(1, 12));
            else if (r < 95) b = 16'($urandom_range(13, 300));
            else             b = 16'($urandom);
            send_load(3'($urandom_range(7)), a, b);
         end else begin
            send_tick();
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      int w;
      reset      = 1'b1;
      calm       = 1'b0;
      req_tvalid = 1'b0;
      req_tuser  = srtf_pkg::REQ_LOAD;
      req_tdata  = '0;
      for (int k = 0; k < NSLOT; k++) begin
         slot_arrival[k] = '0;
         slot_burst[k]   = '0;
         slot_left[k]    = '0;
         slot_loaded[k]  = 1'b0;
         slot_ready[k]   = 1'b0;
         slot_started[k] = 1'b0;
      end
      sched_now  = '0;
      sched_last = NO_SLOT;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_idle_ticks();
      test_preemption();
      test_ties();
      test_zero_burst();
      test_reload_extremes();
      test_random_mix(1080);

      @(negedge clock);
      req_tvalid = 1'b0;
      w = 0;
      while (tick_reports_q.size() != 0 && w < 100000) begin
         @(posedge clock);
         w++;
      end
      repeat (40) @(posedge clock);
      if (tick_reports_q.size() != 0) begin
         $error("%0d tick reports never arrived", tick_reports_q.size());
         mismatches++;
      end
      $display("Covered %0d load and %0d tick transactions: %0d busy, %0d idle, %0d completions",
               loads_sent, ticks_sent, busy_seen, idle_seen, done_seen);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
